// File: hdl/pwm_input_period_duty_meter_top_macros.svh
// assertion macros used by the pwm input meter controller
`ifndef PWM_INPUT_PERIOD_DUTY_METER_TOP_MACROS_SVH
`define PWM_INPUT_PERIOD_DUTY_METER_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, held off during reset
`define PIMD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pimd check failed");

// next-cycle implication, sampled on clock, held off during reset
`define PIMD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pimd check failed");

`endif

// File: hdl/pimd_pkg.sv
// shared types and constants of the pwm input period and duty meter
`default_nettype none

package pimd_pkg;

   // field widths
   localparam int CAP_W      = 16;
   localparam int CH_W       = 1;
   localparam int RATE_W     = 24;
   localparam int FREQ_W     = 16;
   localparam int DUTY_W     = 14;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   // defaults and limits
   localparam int PIMD_CHANNELS = 2;
   localparam logic [RATE_W-1:0] COUNT_RATE_RESET = 24'd1000000;
   localparam logic [FREQ_W-1:0] FREQ_MAX   = 16'd65535;
   localparam logic [DUTY_W-1:0] DUTY_MAX   = 14'd10000;
   localparam logic [DUTY_W-1:0] DUTY_SCALE = 14'd10000;

   // divider width: 30-bit dividend covers both 24-bit rate and 16x14 product
   localparam int DIV_NUM_W = CAP_W + DUTY_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // controller states
   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_MEASURE = 5'b00010,
      ST_START   = 5'b00100,
      ST_DIVIDE  = 5'b01000,
      ST_EMIT    = 5'b10000
   } pimd_state_type;

   // controller to datapath
   typedef struct packed {
      logic arm;
      logic capture;
      logic start_div;
      logic load_out;
   } pimd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ch_ok;
      logic sel_armed;
      logic period_zero;
      logic div_done;
   } pimd_status_type;

endpackage

`default_nettype wire

// File: hdl/pimd_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module pimd_div
   import pimd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_NUM_W-1:0] num,
   input  wire logic [CAP_W-1:0]     den,
   output logic                      done,
   output logic [DIV_NUM_W-1:0]      quot
);

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [CAP_W-1:0]     rem_ff, rem_in;
   logic [CAP_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [CAP_W:0]   rem_sh;
   logic [CAP_W+1:0] trial;
   logic             fits;

   // trial subtract of the shifted remainder
   always_comb begin
      rem_sh = {rem_ff, num_ff[DIV_NUM_W-1]};
      trial  = {1'b0, rem_sh} - {2'b00, den_ff};
      fits   = ~trial[CAP_W+1];
   end

   // next state of the iteration
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_NUM_W-2:0], fits};
         rem_in = fits ? trial[CAP_W-1:0] : rem_sh[CAP_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand registers
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

`default_nettype wire

// File: hdl/pimd_datapath.sv
// per-channel edge store, interval arithmetic, dividers and result word register
`default_nettype none

module pimd_datapath
   import pimd_pkg::*;
#(
   parameter int CHANNELS = PIMD_CHANNELS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CH_W-1:0]   channel,
   input  wire logic [CAP_W-1:0]  rise_capture,
   input  wire logic [CAP_W-1:0]  fall_capture,
   input  wire logic              csr_wr_en,
   input  wire logic [RATE_W-1:0] csr_wr_data,
   input  wire pimd_cmd_type      cmd,
   output pimd_status_type        status,
   output logic [CH_W-1:0]        result_channel,
   output logic [FREQ_W-1:0]      frequency_hz,
   output logic [DUTY_W-1:0]      duty_hundredths,
   output logic                   period_zero
);

   logic [CAP_W-1:0]     first_edge_ff [CHANNELS];
   logic [CHANNELS-1:0]  armed_ff, armed_in;
   logic [CHANNELS-1:0]  ch_match;
   logic [CAP_W-1:0]     sel_edge;

   logic [RATE_W-1:0]    count_rate_ff;
   logic [CAP_W-1:0]     period_ff, high_ff;
   logic [CH_W-1:0]      ch_ff;
   logic [DIV_NUM_W-1:0] duty_num_ff, duty_num_in;
   logic [CAP_W-1:0]     duty_diff;

   logic [FREQ_W-1:0]    freq_ff, freq_in;
   logic [DUTY_W-1:0]    duty_ff, duty_in;
   logic                 pz_ff;
   logic [CH_W-1:0]      rch_ff;

   logic                 freq_done, duty_done;
   logic [DIV_NUM_W-1:0] freq_q, duty_q;
   logic                 per_zero;

   // channel decode and stored edge of the addressed channel
   always_comb begin
      sel_edge = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         ch_match[i] = (32'(channel) == i);
         if (ch_match[i]) begin
            sel_edge = first_edge_ff[i];
         end
      end
   end

   // arm on the first word of a pair, disarm on the second
   always_comb begin
      armed_in = armed_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         if (ch_match[i] && cmd.arm) begin
            armed_in[i] = 1'b1;
         end else if (ch_match[i] && cmd.capture) begin
            armed_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
      end else begin
         armed_ff <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CHANNELS; i++) begin
         if (ch_match[i] && cmd.arm) begin
            first_edge_ff[i] <= rise_capture;
         end
      end
   end

   // count rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_rate_ff <= COUNT_RATE_RESET;
      end else if (csr_wr_en) begin
         count_rate_ff <= csr_wr_data;
      end
   end

   // modular period and high time against the stored rising edge
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         period_ff <= rise_capture - sel_edge;
         high_ff   <= fall_capture - sel_edge;
         ch_ff     <= channel;
      end
   end

   assign per_zero = (period_ff == '0);

   // scaled high time, a full period taken off above 100 percent
   always_comb begin
      duty_diff   = (high_ff > period_ff) ? (high_ff - period_ff) : high_ff;
      duty_num_in = DIV_NUM_W'(duty_diff) * DIV_NUM_W'(DUTY_SCALE);
   end

   always_ff @(posedge clock) begin
      duty_num_ff <= duty_num_in;
   end

   // frequency and duty dividers run side by side
   pimd_div u_freq_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.start_div),
      .num   (DIV_NUM_W'(count_rate_ff)),
      .den   (period_ff),
      .done  (freq_done),
      .quot  (freq_q)
   );

   pimd_div u_duty_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.start_div),
      .num   (duty_num_ff),
      .den   (period_ff),
      .done  (duty_done),
      .quot  (duty_q)
   );

   // saturation and zero-period forcing
   always_comb begin
      freq_in = (freq_q > DIV_NUM_W'(FREQ_MAX)) ? FREQ_MAX : freq_q[FREQ_W-1:0];
      duty_in = (duty_q > DIV_NUM_W'(DUTY_MAX)) ? DUTY_MAX : duty_q[DUTY_W-1:0];
      if (per_zero) begin
         freq_in = '0;
         duty_in = '0;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         freq_ff <= freq_in;
         duty_ff <= duty_in;
         pz_ff   <= per_zero;
         rch_ff  <= ch_ff;
      end
   end

   always_comb begin
      status.ch_ok       = (32'(channel) < CHANNELS);
      status.sel_armed   = |(armed_ff & ch_match);
      status.period_zero = per_zero;
      status.div_done    = freq_done & duty_done;
   end

   assign result_channel  = rch_ff;
   assign frequency_hz    = freq_ff;
   assign duty_hundredths = duty_ff;
   assign period_zero     = pz_ff;

endmodule

`default_nettype wire

// File: hdl/pimd_ctrl.sv
// sequencing controller: word acceptance, divider start, result hand-off
`default_nettype none
`include "pwm_input_period_duty_meter_top_macros.svh"

module pimd_ctrl
   import pimd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   input  wire pimd_status_type status,
   output pimd_cmd_type         cmd
);

   pimd_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   logic           slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign slot_free  = ~rsp_valid_ff | rsp_tready;

   // state sequencing and commands
   always_comb begin
      state_in      = state_ff;
      cmd.arm       = 1'b0;
      cmd.capture   = 1'b0;
      cmd.start_div = 1'b0;
      cmd.load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && status.ch_ok) begin
               if (status.sel_armed) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_MEASURE;
               end else begin
                  cmd.arm = 1'b1;
               end
            end
         end
         ST_MEASURE: begin
            state_in = status.period_zero ? ST_EMIT : ST_START;
         end
         ST_START: begin
            cmd.start_div = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output valid, held until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // checks
   `PIMD_ASSERT_NEXT(a_capture_measures, cmd.capture, state_ff == ST_MEASURE)
   `PIMD_ASSERT_NOW(a_done_in_divide, status.div_done, state_ff == ST_DIVIDE)
   `PIMD_ASSERT_NOW(a_load_slot_free, cmd.load_out, !rsp_valid_ff || rsp_tready)

endmodule

`default_nettype wire

// File: hdl/pwm_input_period_duty_meter_top.sv
// PWM input period and duty meter: top level
//
// Input channel req_*: one word per capture event, channel number in tuser,
// rising and falling counter captures in tdata. The first word of a pair on
// a channel stores its rising capture; the second measures period and high
// time against it, yields one result word and disarms the channel.
// Output channel rsp_*: frequency (count_rate / period, saturated at 65535),
// duty in 0.01 percent (saturated at 10000), channel and zero-period flag.
// csr_wr_en/csr_wr_data write count_rate; write only while idle.
// Sequence: a first-of-pair word or a word for a missing channel is handled
// in idle and leaves the controller ready for the next word. A measuring
// word passes through capture, multiply, divider load, 30 one-bit steps of
// the two parallel dividers, hand-off and result load before its result
// shows, and the next word is taken once the controller is back in idle;
// a zero period skips the dividers. Words are taken one at a time; a
// measuring word holds off the next one until its result is loaded.
// A result waits in the output register while rsp_tready is low; the next
// word is still accepted, but its result waits until the register is free.
// Reset: synchronous, disarms all channels and restores count_rate to 1e6.
`default_nettype none

module pwm_input_period_duty_meter_top
   import pimd_pkg::*;
#(
   parameter int CHANNELS = PIMD_CHANNELS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // rise_capture[15:0], fall_capture[31:16]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // channel[0]
   input  wire logic [CH_W-1:0]       req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // frequency_hz[15:0], duty_hundredths[29:16], zero[31:30]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // result_channel[0], period_zero[1]
   output logic [RSP_USER_W-1:0]      rsp_tuser,
   input  wire logic                  csr_wr_en,
   input  wire logic [RATE_W-1:0]     csr_wr_data
);

   pimd_cmd_type    cmd;
   pimd_status_type status;
   logic [CH_W-1:0]   result_channel;
   logic [FREQ_W-1:0] frequency_hz;
   logic [DUTY_W-1:0] duty_hundredths;
   logic              period_zero;

   pimd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pimd_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .channel         (req_tuser),
      .rise_capture    (req_tdata[CAP_W-1:0]),
      .fall_capture    (req_tdata[2*CAP_W-1:CAP_W]),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .cmd             (cmd),
      .status          (status),
      .result_channel  (result_channel),
      .frequency_hz    (frequency_hz),
      .duty_hundredths (duty_hundredths),
      .period_zero     (period_zero)
   );

   // pack the result word
   assign rsp_tdata = {{(RSP_DATA_W - FREQ_W - DUTY_W){1'b0}}, duty_hundredths, frequency_hz};
   assign rsp_tuser = {period_zero, result_channel};

endmodule

`default_nettype wire
